// ----- rtl/ictu_pkg.sv -----
`default_nettype none

package ictu_pkg;

  localparam logic [1:0] REQ_SPHERE = 2'd0;
  localparam logic [1:0] REQ_BOX    = 2'd1;
  localparam logic [1:0] REQ_DIST   = 2'd2;

  localparam int RADIUS_W = 15;
  localparam int RSUM_W   = 16;
  localparam int R1SQ_W   = 30;
  localparam int DIST_W   = 17;

  typedef struct packed {
    logic [1:0]          req_type;
    logic signed [15:0]  first_x;
    logic signed [15:0]  first_y;
    logic signed [15:0]  first_z;
    logic [14:0]         first_radius;
    logic signed [15:0]  other_x;
    logic signed [15:0]  other_y;
    logic signed [15:0]  other_z;
    logic [14:0]         other_radius;
    logic signed [15:0]  box_max_x;
    logic signed [15:0]  box_max_y;
    logic signed [15:0]  box_max_z;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [16:0] distance;
  } rsp_t;

  // per-item control that rides alongside the arithmetic
  typedef struct packed {
    logic [1:0]        kind;
    logic [RSUM_W-1:0] rsum;
    logic              box_hit;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/integer_collision_test_unit.sv -----
// pipeline: four arithmetic stages, one square-root stage per root bit and the output register
//   lie between accepted request and result valid; the root has min(COORD_BITS, 17) + 1 bits
// throughput: one transaction per cycle; the whole pipeline advances unless a held result
//   is stalled, so a stalled result stops new requests in the same cycle
// reset: synchronous, clears every stage valid bit and the result valid; no other state
`default_nettype none

module integer_collision_test_unit
  import ictu_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  // coordinate width as used internally; above 16 the fields read as non-negative
  localparam int EW = (COORD_BITS <= 16) ? COORD_BITS : 17;
  localparam int RW = EW + 1;
  localparam int SW = 2 * RW;
  localparam int CMPW = SW + R1SQ_W;
  localparam int RTW = RW + RSUM_W;

  logic en;
  assign en = !rsp_valid || !rsp_stall;
  assign req_stall = !en;

  // coordinate extraction
  logic [15:0]          raw_p [3];
  logic [15:0]          raw_q [3];
  logic [15:0]          raw_h [3];
  logic signed [EW-1:0] p     [3];
  logic signed [EW-1:0] q     [3];
  logic signed [EW-1:0] h     [3];

  assign raw_p[0] = req.first_x;
  assign raw_p[1] = req.first_y;
  assign raw_p[2] = req.first_z;
  assign raw_q[0] = req.other_x;
  assign raw_q[1] = req.other_y;
  assign raw_q[2] = req.other_z;
  assign raw_h[0] = req.box_max_x;
  assign raw_h[1] = req.box_max_y;
  assign raw_h[2] = req.box_max_z;

  generate
    if (COORD_BITS <= 16) begin : g_narrow
      for (genvar i = 0; i < 3; i++) begin : g_ax
        assign p[i] = raw_p[i][COORD_BITS-1:0];
        assign q[i] = raw_q[i][COORD_BITS-1:0];
        assign h[i] = raw_h[i][COORD_BITS-1:0];
      end
    end else begin : g_wide
      for (genvar i = 0; i < 3; i++) begin : g_ax
        assign p[i] = {1'b0, raw_p[i]};
        assign q[i] = {1'b0, raw_q[i]};
        assign h[i] = {1'b0, raw_h[i]};
      end
    end
  endgenerate

  // stage a: clamp into the box and pick the second operand
  logic                va;
  logic signed [EW-1:0] a_p [3];
  logic signed [EW-1:0] a_o [3];
  logic [RADIUS_W-1:0]  a_r1;
  side_t                a_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= req_valid;
    end
  end

  generate
    for (genvar i = 0; i < 3; i++) begin : g_clamp
      logic signed [EW-1:0] lo_t;
      logic signed [EW-1:0] cl;
      assign lo_t = (p[i] < h[i]) ? p[i] : h[i];
      assign cl   = (q[i] > lo_t) ? q[i] : lo_t;
      always_ff @(posedge clk) begin
        if (en) begin
          a_p[i] <= p[i];
          a_o[i] <= (req.req_type == REQ_BOX) ? cl : q[i];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      a_r1           <= req.first_radius;
      a_side.kind    <= req.req_type;
      a_side.rsum    <= RSUM_W'(req.first_radius) + RSUM_W'(req.other_radius);
      a_side.box_hit <= 1'b0;
    end
  end

  // stage b: absolute differences
  logic              vb;
  logic [EW-1:0]     b_d [3];
  logic [RADIUS_W-1:0] b_r1;
  side_t             b_side;

  generate
    for (genvar i = 0; i < 3; i++) begin : g_diff
      logic [EW:0] dd;
      logic [EW:0] mag;
      assign dd  = {a_p[i][EW-1], a_p[i]} - {a_o[i][EW-1], a_o[i]};
      assign mag = dd[EW] ? (-dd) : dd;
      always_ff @(posedge clk) begin
        if (en) begin
          b_d[i] <= mag[EW-1:0];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_r1   <= a_r1;
      b_side <= a_side;
    end
  end

  // stage c: squares
  logic              vc;
  logic [2*EW-1:0]   c_sq [3];
  logic [R1SQ_W-1:0] c_r1sq;
  side_t             c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c_sq[i] <= (2*EW)'(b_d[i]) * (2*EW)'(b_d[i]);
      end
      c_r1sq <= R1SQ_W'(b_r1) * R1SQ_W'(b_r1);
      c_side <= b_side;
    end
  end

  // stage d feeds the root pipeline: squared distance and the box decision
  logic [SW-1:0] sum_sq;
  side_t         d_side;

  always_comb begin
    sum_sq         = SW'(c_sq[0]) + SW'(c_sq[1]) + SW'(c_sq[2]);
    d_side         = c_side;
    d_side.box_hit = (CMPW'(sum_sq) <= CMPW'(c_r1sq));
  end

  // floor square root, one root bit per stage
  logic            v_r    [RW+1];
  logic [SW-1:0]   n_r    [RW+1];
  logic [RW+1:0]   rem_r  [RW+1];
  logic [RW-1:0]   root_r [RW+1];
  side_t           side_r [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]    <= sum_sq;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= d_side;
    end
  end

  generate
    for (genvar k = 0; k < RW; k++) begin : g_root
      logic [RW+3:0] rem_sh;
      logic [RW+3:0] trial;
      logic          ge;
      logic [RW+3:0] rem_sub;
      assign rem_sh  = {rem_r[k], n_r[k][SW-1 -: 2]};
      assign trial   = (RW+4)'({root_r[k], 2'b01});
      assign ge      = (rem_sh >= trial);
      assign rem_sub = ge ? (rem_sh - trial) : rem_sh;
      always_ff @(posedge clk) begin
        if (rst) begin
          v_r[k+1] <= 1'b0;
        end else if (en) begin
          v_r[k+1] <= v_r[k];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          n_r[k+1]    <= n_r[k] << 2;
          rem_r[k+1]  <= rem_sub[RW+1:0];
          root_r[k+1] <= {root_r[k][RW-2:0], ge};
          side_r[k+1] <= side_r[k];
        end
      end
    end
  endgenerate

  // output register
  logic [RTW-1:0] root_ext;
  rsp_t           rsp_next;
  logic [1:0]     rsp_kind;

  assign root_ext = RTW'(root_r[RW]);

  always_comb begin
    rsp_next = '0;
    case (side_r[RW].kind)
      REQ_SPHERE: begin
        rsp_next.hit      = (RTW'(side_r[RW].rsum) > root_ext);
        rsp_next.distance = root_ext[DIST_W-1:0];
      end
      REQ_BOX: begin
        rsp_next.hit = side_r[RW].box_hit;
      end
      REQ_DIST: begin
        rsp_next.distance = root_ext[DIST_W-1:0];
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (en) begin
      rsp_valid <= v_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp      <= rsp_next;
      rsp_kind <= side_r[RW].kind;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> va)
    else $error("accepted request did not enter the first stage");

  a_root_remainder : assert property (@(posedge clk) disable iff (rst)
    v_r[RW] |-> rem_r[RW] <= (RW+2)'({root_r[RW], 1'b0}))
    else $error("square root remainder out of bound");

  a_dist_no_hit : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind == REQ_DIST) |-> !rsp.hit)
    else $error("distance request reported a hit");

  a_box_no_dist : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_kind == REQ_BOX) |-> rsp.distance == '0)
    else $error("box test reported a distance");
`endif

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ictu_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;   // pipeline is 22 deep at the default coordinate width
  localparam int DRAIN_LIMIT   = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  rsp_t expected_contacts[$];
  rsp_t oldest_contact;
  int contact_errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  integer_collision_test_unit uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic logic [63:0] floor_root(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 17; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  function automatic longint sq_len(longint dx, longint dy, longint dz);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic longint clamp_into(longint c, longint lo, longint hi);
    longint t;
    t = (c < hi) ? c : hi;
    return (lo > t) ? lo : t;
  endfunction

  function automatic longint centre_gap_sq(req_t r);
    return sq_len(longint'(r.first_x) - r.other_x, longint'(r.first_y) - r.other_y,
                  longint'(r.first_z) - r.other_z);
  endfunction

  // squared gap from the sphere centre to its nearest point in the box
  function automatic longint box_gap_sq(req_t r);
    longint cx, cy, cz;
    cx = clamp_into(r.first_x, r.other_x, r.box_max_x);
    cy = clamp_into(r.first_y, r.other_y, r.box_max_y);
    cz = clamp_into(r.first_z, r.other_z, r.box_max_z);
    return sq_len(longint'(r.first_x) - cx, longint'(r.first_y) - cy, longint'(r.first_z) - cz);
  endfunction

  function automatic rsp_t predict_contact(req_t r);
    rsp_t e;
    logic [63:0] root;
    longint rad;
    e = '0;
    case (r.req_type)
      REQ_SPHERE: begin
        root = floor_root(centre_gap_sq(r));
        e.distance = root[16:0];
        e.hit = (64'(r.first_radius) + 64'(r.other_radius)) > root;
      end
      REQ_BOX: begin
        rad = longint'(r.first_radius);
        e.hit = box_gap_sq(r) <= rad * rad;
      end
      REQ_DIST: begin
        root = floor_root(centre_gap_sq(r));
        e.distance = root[16:0];
      end
      default: ;
    endcase
    return e;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int rand_span();
    return (1 << $urandom_range(16, 0)) - 1;
  endfunction

  function automatic longint offset(int span);
    return longint'(int'($urandom_range(2 * span))) - span;
  endfunction

  function automatic req_t mk(logic [1:0] k, int ax, int ay, int az, int ar,
                              int bx, int by, int bz, int br, int hx, int hy, int hz);
    req_t r;
    r.req_type = k;
    r.first_x = 16'(ax);
    r.first_y = 16'(ay);
    r.first_z = 16'(az);
    r.first_radius = 15'(ar);
    r.other_x = 16'(bx);
    r.other_y = 16'(by);
    r.other_z = 16'(bz);
    r.other_radius = 15'(br);
    r.box_max_x = 16'(hx);
    r.box_max_y = 16'(hy);
    r.box_max_z = 16'(hz);
    return r;
  endfunction

  function automatic req_t noise_item();
    return mk(2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // second sphere placed so the radius sum lands within two of the centre distance
  function automatic req_t sphere_near_contact();
    req_t r;
    int span;
    longint root, rsum, r1;
    r = noise_item();
    r.req_type = REQ_SPHERE;
    if ($urandom_range(4) != 0) begin
      span = rand_span();
      r.other_x = clip16(r.first_x + offset(span));
      r.other_y = clip16(r.first_y + offset(span));
      r.other_z = clip16(r.first_z + offset(span));
      root = longint'(floor_root(centre_gap_sq(r)));
      rsum = root + int'($urandom_range(4)) - 2;
      if (rsum < 0) rsum = 0;
      if (rsum > 65534) rsum = 65534;
      r1 = $urandom_range((rsum > 32767) ? 32767 : rsum, (rsum > 32767) ? rsum - 32767 : 0);
      r.first_radius = 15'(r1);
      r.other_radius = 15'(rsum - r1);
    end
    return r;
  endfunction

  function automatic void box_axis(input int span, output logic signed [15:0] lo,
                                   output logic signed [15:0] hi, output logic signed [15:0] c);
    longint a, b;
    a = longint'($signed(16'($urandom)));
    b = a + int'($urandom_range(span));
    c = clip16(a + int'($urandom_range(3 * span)) - span);
    // occasionally an inverted box
    if ($urandom_range(7) == 0) begin
      lo = clip16(b);
      hi = clip16(a);
    end else begin
      lo = clip16(a);
      hi = clip16(b);
    end
  endfunction

  function automatic req_t box_near_edge();
    req_t r;
    int span;
    longint rad;
    r = noise_item();
    r.req_type = REQ_BOX;
    if ($urandom_range(4) != 0) begin
      span = rand_span();
      box_axis(span, r.other_x, r.box_max_x, r.first_x);
      box_axis(span, r.other_y, r.box_max_y, r.first_y);
      box_axis(span, r.other_z, r.box_max_z, r.first_z);
      rad = longint'(floor_root(box_gap_sq(r))) + int'($urandom_range(2)) - 1;
      if (rad < 0) rad = 0;
      if (rad > 32767) rad = 32767;
      r.first_radius = 15'(rad);
    end
    return r;
  endfunction

  function automatic req_t point_pair();
    req_t r;
    int span;
    r = noise_item();
    r.req_type = REQ_DIST;
    if ($urandom_range(3) != 0) begin
      span = rand_span();
      r.other_x = clip16(r.first_x + offset(span));
      r.other_y = clip16(r.first_y + offset(span));
      r.other_z = clip16(r.first_z + offset(span));
    end
    return r;
  endfunction

  // ---------------- driving and checking ----------------

  task automatic apply_idling(int phase);
    case (phase)
      0: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct = 55;
        stall_pct = 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct = 55;
      end
      default: begin
        idle_pct = 16;
        stall_pct = 16;
      end
    endcase
  endtask

  // entered and left just after a falling edge
  task automatic send_item(req_t item);
    if (int'($urandom_range(99)) < idle_pct) begin
      req_valid <= 1'b0;
      do @(negedge clk); while (int'($urandom_range(99)) < idle_pct);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_contacts.push_back(predict_contact(item));
    @(negedge clk);
  endtask

  task automatic report_mismatch(string msg);
    contact_errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(negedge clk) begin
    rsp_stall <= !rst && (int'($urandom_range(99)) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_contacts.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        oldest_contact = expected_contacts.pop_front();
        if (rsp.hit !== oldest_contact.hit)
          report_mismatch($sformatf("hit %b, predicted %b", rsp.hit, oldest_contact.hit));
        if (rsp.distance !== oldest_contact.distance)
          report_mismatch($sformatf("distance %0d, predicted %0d", rsp.distance,
                                    oldest_contact.distance));
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed_cases();
    apply_idling(0);
    // coincident centres: zero radii miss, any radius hits
    send_item(mk(REQ_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(REQ_SPHERE, 7, -7, 7, 1, 7, -7, 7, 0, 0, 0, 0));
    // radius sum equal to the distance is not a hit, one more is
    send_item(mk(REQ_SPHERE, 0, 0, 0, 4, 10, 0, 0, 6, 0, 0, 0));
    send_item(mk(REQ_SPHERE, 0, 0, 0, 5, 10, 0, 0, 6, 0, 0, 0));
    // opposite corners of the coordinate range, largest radii
    send_item(mk(REQ_SPHERE, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767,
                 0, 0, 0));
    send_item(mk(REQ_SPHERE, -32767, 0, 0, 32767, 32767, 0, 0, 32767, 0, 0, 0));
    send_item(mk(REQ_SPHERE, -32766, 0, 0, 32767, 32767, 0, 0, 32767, 0, 0, 0));
    send_item(mk(REQ_SPHERE, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    // centre inside the box, zero radius
    send_item(mk(REQ_BOX, 0, 0, 0, 0, -5, -5, -5, 0, 5, 5, 5));
    // touching a face exactly, then one short
    send_item(mk(REQ_BOX, 10, 0, 0, 5, -5, -5, -5, 0, 5, 5, 5));
    send_item(mk(REQ_BOX, 10, 0, 0, 4, -5, -5, -5, 0, 5, 5, 5));
    // nearest point on an edge
    send_item(mk(REQ_BOX, 8, 9, 0, 5, 0, 0, 0, 0, 5, 5, 0));
    send_item(mk(REQ_BOX, 8, 9, 0, 4, 0, 0, 0, 0, 5, 5, 0));
    // inverted box clamps to its minimum corner
    send_item(mk(REQ_BOX, 0, 0, 0, 17, 10, 10, 10, 0, -10, -10, -10));
    send_item(mk(REQ_BOX, 0, 0, 0, 18, 10, 10, 10, 0, -10, -10, -10));
    // widest gap against largest radius, and a degenerate box at the centre
    send_item(mk(REQ_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767,
                 32767, 32767, 32767));
    send_item(mk(REQ_BOX, 32767, 32767, 32767, 0, 32767, 32767, 32767, 0,
                 32767, 32767, 32767));
    // distances; radius fields must not matter
    send_item(mk(REQ_DIST, 0, 0, 0, 32767, 3, 4, 0, 32767, -1, -1, -1));
    send_item(mk(REQ_DIST, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk(REQ_DIST, 32767, 32767, 32767, 0, -32768, -32768, -32768, 0, 0, 0, 0));
    send_item(mk(REQ_DIST, -32768, 0, 0, 0, -32768, 0, 0, 0, 0, 0, 0));
    // unused selector
    send_item(mk(REQ_UNUSED, -1, -1, -1, 32767, -1, -1, -1, 32767, -1, -1, -1));
    send_item(mk(REQ_UNUSED, 0, 0, 0, 0, 100, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_sphere_pairs(int n);
    for (int ph = 0; ph < 4; ph++) begin
      apply_idling(ph);
      repeat (n / 4) send_item(sphere_near_contact());
    end
  endtask

  task automatic test_box_contacts(int n);
    for (int ph = 3; ph >= 0; ph--) begin
      apply_idling(ph);
      repeat (n / 4) send_item(box_near_edge());
    end
  endtask

  task automatic test_point_distance(int n);
    for (int ph = 0; ph < 4; ph++) begin
      apply_idling((ph + 2) % 4);
      repeat (n / 4) send_item(point_pair());
    end
  endtask

  task automatic test_mixed_stream(int n);
    req_t item;
    for (int ph = 0; ph < 4; ph++) begin
      apply_idling((ph + 1) % 4);
      repeat (n / 4) begin
        case ($urandom_range(9))
          0, 1: item = noise_item();
          2, 3, 4: item = sphere_near_contact();
          5, 6, 7: item = box_near_edge();
          default: item = point_pair();
        endcase
        send_item(item);
      end
    end
  endtask

  initial begin
    int waited;
    waited = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_sphere_pairs(280);
    test_box_contacts(280);
    test_point_distance(200);
    test_mixed_stream(320);
    req_valid <= 1'b0;
    while (expected_contacts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_contacts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_contacts.size()));
    if (contact_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
